// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the mixer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define EPM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is low.
`define EPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/epm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package epm_pkg;

    localparam int CHANNELS     = 4;
    localparam int SAMPLE_BITS  = 24;
    // Table size must be a power of two: the position math below relies on it.
    localparam int SINE_ENTRIES = 256;
    localparam int SINE_LOG2    = $clog2(SINE_ENTRIES);
    localparam int IDX_W        = SINE_LOG2 + 1;
    localparam int FRAC_W       = 24;
    localparam int MIX_W        = 24;
    localparam int GAIN_W       = FRAC_W + 1;
    localparam int POS_W        = FRAC_W + SINE_LOG2 + 1;
    localparam int COEF_W       = 16;
    localparam int ACT_W        = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int NSTAGE       = 7;

    localparam logic [MIX_W-1:0]      MIX_FULL     = {MIX_W{1'b1}};
    localparam logic [GAIN_W-1:0]     GAIN_ONE     = {1'b1, {FRAC_W{1'b0}}};
    localparam logic [COEF_W-1:0]     RST_TARGET   = 16'hFFFF;
    localparam logic [COEF_W-1:0]     RST_COEFF    = 16'd273;
    localparam logic [ACT_W-1:0]      RST_ACTIVE   = 3'd4;
    localparam logic [ACT_W-1:0]      MAX_ACTIVE   = ACT_W'(CHANNELS);

    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] t_lane_words;
    typedef logic [GAIN_W-1:0] t_sine_tab [0:SINE_ENTRIES];

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIX_TARGET   = 2'd0,
        CFG_SMOOTH_COEFF = 2'd1,
        CFG_ACTIVE_CH    = 2'd2
    } t_cfg_reg;

    // en[s]: stage s takes the beat of stage s-1. vld[s]: stage s holds a beat.
    typedef struct packed {
        logic [NSTAGE:1] en;
        logic [NSTAGE:1] vld;
    } t_pipe_ctl;

    // Quarter-wave sine, 1.0 = 2^24, from an eight-term Horner series in Q30.
    function automatic t_sine_tab f_build_sine();
        t_sine_tab tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        for (int k = 0; k <= SINE_ENTRIES; k++) begin
            x  = (HALF_PI_Q30 * 64'(k) + 64'(SINE_ENTRIES / 2)) / SINE_ENTRIES;
            x2 = (x * x) >> 30;
            t  = Q30_ONE;
            t  = Q30_ONE - ((x2 * t) >> 30) / 210;
            t  = Q30_ONE - ((x2 * t) >> 30) / 156;
            t  = Q30_ONE - ((x2 * t) >> 30) / 110;
            t  = Q30_ONE - ((x2 * t) >> 30) / 72;
            t  = Q30_ONE - ((x2 * t) >> 30) / 42;
            t  = Q30_ONE - ((x2 * t) >> 30) / 20;
            t  = Q30_ONE - ((x2 * t) >> 30) / 6;
            s  = (x * t) >> 30;
            s  = (s + 64'd32) >> 6;
            if (s > 64'(GAIN_ONE)) begin
                s = 64'(GAIN_ONE);
            end
            tab[k] = GAIN_W'(s);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = f_build_sine();

endpackage

`default_nettype wire

// ----- hw/rtl/epm_frame_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface epm_frame_if;
    logic             valid;
    logic             ready;
    epm_pkg::t_sample dry_0;
    epm_pkg::t_sample dry_1;
    epm_pkg::t_sample dry_2;
    epm_pkg::t_sample dry_3;
    epm_pkg::t_sample wet_0;
    epm_pkg::t_sample wet_1;
    epm_pkg::t_sample wet_2;
    epm_pkg::t_sample wet_3;
    logic             block_end;

    modport source (
        output valid, dry_0, dry_1, dry_2, dry_3, wet_0, wet_1, wet_2, wet_3, block_end,
        input  ready
    );
    modport sink (
        input  valid, dry_0, dry_1, dry_2, dry_3, wet_0, wet_1, wet_2, wet_3, block_end,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/epm_mix_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface epm_mix_if;
    logic                               valid;
    logic                               ready;
    epm_pkg::t_sample                   out_0;
    epm_pkg::t_sample                   out_1;
    epm_pkg::t_sample                   out_2;
    epm_pkg::t_sample                   out_3;
    logic [epm_pkg::SAMPLE_BITS-1:0]    block_peak;
    logic                               peak_valid;

    modport source (
        output valid, out_0, out_1, out_2, out_3, block_peak, peak_valid,
        input  ready
    );
    modport sink (
        input  valid, out_0, out_1, out_2, out_3, block_peak, peak_valid,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/epm_gain.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Mix smoother and gain path: stages 1 to 4 of the pipeline.
module epm_gain (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire epm_pkg::t_pipe_ctl               i_ctl,
    input  wire logic                             i_acc,
    input  wire logic [epm_pkg::COEF_W-1:0]       i_mix_target,
    input  wire logic [epm_pkg::COEF_W-1:0]       i_smooth_coeff,
    output logic      [epm_pkg::GAIN_W-1:0]       o_wet_gain,
    output logic      [epm_pkg::GAIN_W-1:0]       o_dry_gain
);

    localparam int MIX_W   = epm_pkg::MIX_W;
    localparam int FRAC_W  = epm_pkg::FRAC_W;
    localparam int GAIN_W  = epm_pkg::GAIN_W;
    localparam int POS_W   = epm_pkg::POS_W;
    localparam int IDX_W   = epm_pkg::IDX_W;
    localparam int LOG2N   = epm_pkg::SINE_LOG2;
    localparam int COEF_W  = epm_pkg::COEF_W;
    localparam int SPROD_W = MIX_W + COEF_W;
    localparam int X_W     = MIX_W + LOG2N;
    localparam int IPROD_W = GAIN_W + FRAC_W;
    localparam logic [SPROD_W-1:0] SROUND   = SPROD_W'(1) << (COEF_W - 1);
    localparam logic [POS_W-1:0]   POS_SPAN = {1'b1, {(POS_W-1){1'b0}}};

    // smoother
    logic [MIX_W-1:0]   r_mix;
    logic [MIX_W-1:0]   n_mix;
    logic [MIX_W-1:0]   w_target;
    logic [MIX_W-1:0]   w_dist;
    logic [MIX_W-1:0]   w_step;
    logic [SPROD_W-1:0] w_sprod;
    logic               w_up;

    assign w_target = {i_mix_target, i_mix_target[COEF_W-1:COEF_W-(MIX_W-COEF_W)]};
    assign w_up     = w_target >= r_mix;
    assign w_dist   = w_up ? (w_target - r_mix) : (r_mix - w_target);
    assign w_sprod  = SPROD_W'(w_dist) * SPROD_W'(i_smooth_coeff) + SROUND;
    assign w_step   = w_sprod[SPROD_W-1:COEF_W];
    assign n_mix    = w_up ? (r_mix + w_step) : (r_mix - w_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mix <= epm_pkg::MIX_FULL;
        end else if (i_acc) begin
            r_mix <= n_mix;
        end
    end

    // stage 1: smoothed mix of this frame
    logic [MIX_W-1:0] r_mix1;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_mix1 <= n_mix;
        end
    end

    // table position: m * N * 2^24 / (2^24 - 1), as m * N plus a small quotient
    logic [X_W-1:0]    w_x;
    logic [LOG2N-1:0]  w_q0;
    logic [FRAC_W:0]   w_csum;
    logic              w_corr;
    logic [LOG2N:0]    w_quo;
    logic [POS_W-1:0]  w_pos [2];
    logic [IDX_W-1:0]  w_idx [2];
    logic [FRAC_W-1:0] w_frac [2];
    logic [GAIN_W-1:0] w_ta [2];
    logic [GAIN_W-1:0] w_tb [2];

    assign w_x      = {r_mix1, {LOG2N{1'b0}}};
    assign w_q0     = w_x[X_W-1:FRAC_W];
    assign w_csum   = {1'b0, w_x[FRAC_W-1:0]} + (FRAC_W+1)'(w_q0);
    assign w_corr   = w_csum >= {1'b0, epm_pkg::MIX_FULL};
    assign w_quo    = {1'b0, w_q0} + (LOG2N+1)'(w_corr);
    // wet position in slot 0, dry (mirrored) in slot 1
    assign w_pos[0] = {1'b0, w_x} + POS_W'(w_quo);
    assign w_pos[1] = POS_SPAN - w_pos[0];

    always_comb begin
        for (int p = 0; p < 2; p++) begin
            w_idx[p]  = w_pos[p][POS_W-1:FRAC_W];
            w_frac[p] = w_pos[p][FRAC_W-1:0];
            if (w_idx[p][IDX_W-1]) begin
                w_ta[p] = epm_pkg::SINE_TAB[epm_pkg::SINE_ENTRIES];
                w_tb[p] = epm_pkg::SINE_TAB[epm_pkg::SINE_ENTRIES];
            end else begin
                w_ta[p] = epm_pkg::SINE_TAB[w_idx[p]];
                w_tb[p] = epm_pkg::SINE_TAB[w_idx[p] + IDX_W'(1)];
            end
        end
    end

    // stage 2: neighbouring table entries
    logic [GAIN_W-1:0] r_a2 [2];
    logic [GAIN_W-1:0] r_b2 [2];
    logic [FRAC_W-1:0] r_frac2 [2];

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            for (int p = 0; p < 2; p++) begin
                r_a2[p]    <= w_ta[p];
                r_b2[p]    <= w_tb[p];
                r_frac2[p] <= w_frac[p];
            end
        end
    end

    // stage 3: interpolation offset
    logic              w_iup [2];
    logic [GAIN_W-1:0] w_diff [2];
    logic [IPROD_W-1:0] w_iprod [2];
    logic [GAIN_W-1:0] r_a3 [2];
    logic [GAIN_W-1:0] r_off3 [2];
    logic              r_up3 [2];

    always_comb begin
        for (int p = 0; p < 2; p++) begin
            w_iup[p]   = r_b2[p] >= r_a2[p];
            w_diff[p]  = w_iup[p] ? (r_b2[p] - r_a2[p]) : (r_a2[p] - r_b2[p]);
            w_iprod[p] = IPROD_W'(w_diff[p]) * IPROD_W'(r_frac2[p]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            for (int p = 0; p < 2; p++) begin
                r_a3[p]   <= r_a2[p];
                r_up3[p]  <= w_iup[p];
                r_off3[p] <= w_iprod[p][IPROD_W-1:FRAC_W];
            end
        end
    end

    // stage 4: gains
    logic [GAIN_W-1:0] r_gain [2];

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[4]) begin
            for (int p = 0; p < 2; p++) begin
                r_gain[p] <= r_up3[p] ? (r_a3[p] + r_off3[p]) : (r_a3[p] - r_off3[p]);
            end
        end
    end

    assign o_wet_gain = r_gain[0];
    assign o_dry_gain = r_gain[1];

    `EPM_ASSERT_NEXT(a_mix_rise_no_overshoot, i_clk, i_rst_n, i_acc && w_up, (r_mix >= $past(r_mix)) && (r_mix <= $past(w_target)), "mix overshot the target while rising")
    `EPM_ASSERT_NEXT(a_mix_fall_no_overshoot, i_clk, i_rst_n, i_acc && !w_up, (r_mix <= $past(r_mix)) && (r_mix >= $past(w_target)), "mix overshot the target while falling")
    `EPM_ASSERT_NOW(a_gain_in_range, i_clk, i_rst_n, i_ctl.vld[4], (r_gain[0] <= epm_pkg::GAIN_ONE) && (r_gain[1] <= epm_pkg::GAIN_ONE), "gain above unity")

endmodule

`default_nettype wire

// ----- hw/rtl/epm_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// One channel: delays its samples to meet the gains, mixes, rounds, saturates, mutes if inactive.
module epm_lane (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire epm_pkg::t_pipe_ctl               i_ctl,
    input  wire epm_pkg::t_sample                 i_dry,
    input  wire epm_pkg::t_sample                 i_wet,
    input  wire logic [epm_pkg::GAIN_W-1:0]       i_dry_gain,
    input  wire logic [epm_pkg::GAIN_W-1:0]       i_wet_gain,
    input  wire logic                             i_active,
    output epm_pkg::t_sample                      o_out,
    output logic [epm_pkg::SAMPLE_BITS-1:0]       o_mag
);

    localparam int SB     = epm_pkg::SAMPLE_BITS;
    localparam int GAIN_W = epm_pkg::GAIN_W;
    localparam int FRAC_W = epm_pkg::FRAC_W;
    localparam int PROD_W = SB + GAIN_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int Q_W    = SUM_W - FRAC_W;
    localparam logic signed [SUM_W-1:0] ROUND = SUM_W'(1) << (FRAC_W - 1);
    localparam logic signed [SB-1:0]    SMAX  = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0]    SMIN  = {1'b1, {(SB-1){1'b0}}};

    // stages 1..4: hold samples while the gains are worked out
    epm_pkg::t_sample r_dry [1:4];
    epm_pkg::t_sample r_wet [1:4];

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_dry[1] <= i_dry;
            r_wet[1] <= i_wet;
        end
        for (int s = 2; s <= 4; s++) begin
            if (i_ctl.en[s]) begin
                r_dry[s] <= r_dry[s-1];
                r_wet[s] <= r_wet[s-1];
            end
        end
    end

    // stage 5: products
    logic signed [GAIN_W:0]   w_dg;
    logic signed [GAIN_W:0]   w_wg;
    logic signed [PROD_W-1:0] r_pd;
    logic signed [PROD_W-1:0] r_pw;

    assign w_dg = signed'({1'b0, i_dry_gain});
    assign w_wg = signed'({1'b0, i_wet_gain});

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[5]) begin
            r_pd <= PROD_W'(r_dry[4]) * PROD_W'(w_dg);
            r_pw <= PROD_W'(r_wet[4]) * PROD_W'(w_wg);
        end
    end

    // stage 6: round to nearest (floor of sum + half), saturate, magnitude
    logic signed [SUM_W-1:0] w_sum;
    logic signed [Q_W-1:0]   w_q;
    logic                    w_ovf;
    epm_pkg::t_sample        w_sat;
    epm_pkg::t_sample        w_out;
    logic [SB-1:0]           w_mag;
    epm_pkg::t_sample        r_out;
    logic [SB-1:0]           r_mag;

    assign w_sum = SUM_W'(r_pd) + SUM_W'(r_pw) + ROUND;
    assign w_q   = w_sum[SUM_W-1:FRAC_W];
    assign w_ovf = (w_q[Q_W-1:SB-1] != {(Q_W-SB+1){1'b0}})
                && (w_q[Q_W-1:SB-1] != {(Q_W-SB+1){1'b1}});

    always_comb begin
        if (w_ovf) begin
            w_sat = w_q[Q_W-1] ? SMIN : SMAX;
        end else begin
            w_sat = w_q[SB-1:0];
        end
        w_out = i_active ? w_sat : '0;
        w_mag = w_out[SB-1] ? (~w_out + SB'(1)) : w_out;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[6]) begin
            r_out <= w_out;
            r_mag <= w_mag;
        end
    end

    assign o_out = r_out;
    assign o_mag = r_mag;

    `EPM_ASSERT_NEXT(a_idle_lane_quiet, i_clk, i_rst_n, i_ctl.en[6] && !i_active, (r_out == '0) && (r_mag == '0), "inactive lane produced a nonzero sample")

endmodule

`default_nettype wire

// ----- hw/rtl/epm_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Merge stage: frame peak over the lanes, block peak tracking, output register.
module epm_merge (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire epm_pkg::t_pipe_ctl               i_ctl,
    input  wire logic                             i_block_end,
    input  wire epm_pkg::t_lane_words             i_out,
    input  wire epm_pkg::t_lane_words             i_mag,
    output epm_pkg::t_lane_words                  o_out,
    output logic [epm_pkg::SAMPLE_BITS-1:0]       o_block_peak,
    output logic                                  o_peak_valid
);

    localparam int SB = epm_pkg::SAMPLE_BITS;

    // block-end flag rides along stages 1..6
    logic r_be [1:6];

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_be[1] <= i_block_end;
        end
        for (int s = 2; s <= 6; s++) begin
            if (i_ctl.en[s]) begin
                r_be[s] <= r_be[s-1];
            end
        end
    end

    logic [SB-1:0] w_frame_peak;
    logic [SB-1:0] w_peak;
    logic [SB-1:0] r_run;
    logic          w_load;

    assign w_load = i_ctl.en[7] && i_ctl.vld[6];

    always_comb begin
        w_frame_peak = '0;
        for (int c = 0; c < epm_pkg::CHANNELS; c++) begin
            if (i_mag[c] > w_frame_peak) begin
                w_frame_peak = i_mag[c];
            end
        end
        w_peak = (w_frame_peak > r_run) ? w_frame_peak : r_run;
    end

    // running peak: clear on the block end, else keep the max
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (w_load) begin
            r_run <= r_be[6] ? '0 : w_peak;
        end
    end

    epm_pkg::t_lane_words r_out;
    logic [SB-1:0]        r_bp;
    logic                 r_pv;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[7]) begin
            r_out <= i_out;
            r_bp  <= r_be[6] ? w_peak : '0;
            r_pv  <= r_be[6];
        end
    end

    assign o_out        = r_out;
    assign o_block_peak = r_bp;
    assign o_peak_valid = r_pv;

    `EPM_ASSERT_NOW(a_peak_zero_midblock, i_clk, i_rst_n, i_ctl.vld[7] && !r_pv, r_bp == '0, "block peak shown on a frame that does not end a block")
    `EPM_ASSERT_NEXT(a_peak_cleared_at_end, i_clk, i_rst_n, w_load && r_be[6], r_run == '0, "running peak not cleared after block end")

endmodule

`default_nettype wire

// ----- hw/rtl/equal_power_dry_wet_mixer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Port      Dir  Handshake     Beat contents
// i_frame   in   valid/ready   dry_0..3, wet_0..3 (24b signed), block_end
// o_mix     out  valid/ready   out_0..3 (24b signed), block_peak (24b), peak_valid
// i_cfg_*   in   write enable  idx 0 mix_target, 1 smooth_coeff, 2 active_channels
//
// Seven register stages: a frame's result is offered when its beat reaches stage 7.
// One frame per cycle sustained while o_mix is ready; the smoother register (one
// 24x16 multiply and add per beat) sets that limit. Stages fill independently, so a
// held output beat only stops the stages behind it once they are full.
// Reset clears all stage valids and the running block peak, loads register defaults
// and sets the mix to fully wet.
module equal_power_dry_wet_mixer (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    epm_frame_if.sink                                 i_frame,
    epm_mix_if.source                                 o_mix,
    input  wire logic                                 i_cfg_we,
    input  wire logic [epm_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [epm_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int NSTAGE   = epm_pkg::NSTAGE;
    localparam int CHANNELS = epm_pkg::CHANNELS;
    localparam int ACT_W    = epm_pkg::ACT_W;

    // configuration registers
    logic [epm_pkg::COEF_W-1:0] r_mix_target;
    logic [epm_pkg::COEF_W-1:0] r_smooth_coeff;
    logic [ACT_W-1:0]           r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mix_target   <= epm_pkg::RST_TARGET;
            r_smooth_coeff <= epm_pkg::RST_COEFF;
            r_active       <= epm_pkg::RST_ACTIVE;
        end else if (i_cfg_we) begin
            unique case (epm_pkg::t_cfg_reg'(i_cfg_idx))
                epm_pkg::CFG_MIX_TARGET: begin
                    r_mix_target <= i_cfg_data;
                end
                epm_pkg::CFG_SMOOTH_COEFF: begin
                    r_smooth_coeff <= i_cfg_data;
                end
                epm_pkg::CFG_ACTIVE_CH: begin
                    r_active <= i_cfg_data[ACT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // pipeline control: a stage advances when empty or when the next one advances
    logic [NSTAGE:1]   r_vld;
    logic [NSTAGE+1:1] w_en;
    logic              w_acc;
    epm_pkg::t_pipe_ctl w_ctl;

    always_comb begin
        w_en[NSTAGE+1] = o_mix.ready;
        for (int s = NSTAGE; s >= 1; s--) begin
            w_en[s] = !r_vld[s] || w_en[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= i_frame.valid;
            end
            for (int s = 2; s <= NSTAGE; s++) begin
                if (w_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    assign w_acc         = i_frame.valid && w_en[1];
    assign i_frame.ready = w_en[1];
    assign w_ctl.en      = w_en[NSTAGE:1];
    assign w_ctl.vld     = r_vld;

    // gains
    logic [epm_pkg::GAIN_W-1:0] w_wet_gain;
    logic [epm_pkg::GAIN_W-1:0] w_dry_gain;

    epm_gain u_gain (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_acc          (w_acc),
        .i_mix_target   (r_mix_target),
        .i_smooth_coeff (r_smooth_coeff),
        .o_wet_gain     (w_wet_gain),
        .o_dry_gain     (w_dry_gain)
    );

    // lanes
    epm_pkg::t_sample     w_dry [CHANNELS];
    epm_pkg::t_sample     w_wet [CHANNELS];
    epm_pkg::t_lane_words w_lane_out;
    epm_pkg::t_lane_words w_lane_mag;
    logic [ACT_W-1:0]     w_nact;

    assign w_dry[0] = i_frame.dry_0;
    assign w_dry[1] = i_frame.dry_1;
    assign w_dry[2] = i_frame.dry_2;
    assign w_dry[3] = i_frame.dry_3;
    assign w_wet[0] = i_frame.wet_0;
    assign w_wet[1] = i_frame.wet_1;
    assign w_wet[2] = i_frame.wet_2;
    assign w_wet[3] = i_frame.wet_3;

    // counts above the lane count act as all lanes
    assign w_nact = (r_active > epm_pkg::MAX_ACTIVE) ? epm_pkg::MAX_ACTIVE : r_active;

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        epm_pkg::t_sample w_out;

        epm_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_dry      (w_dry[g]),
            .i_wet      (w_wet[g]),
            .i_dry_gain (w_dry_gain),
            .i_wet_gain (w_wet_gain),
            .i_active   (ACT_W'(g) < w_nact),
            .o_out      (w_out),
            .o_mag      (w_lane_mag[g])
        );

        assign w_lane_out[g] = w_out;
    end

    // merge and output register
    epm_pkg::t_lane_words w_mout;

    epm_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_block_end  (i_frame.block_end),
        .i_out        (w_lane_out),
        .i_mag        (w_lane_mag),
        .o_out        (w_mout),
        .o_block_peak (o_mix.block_peak),
        .o_peak_valid (o_mix.peak_valid)
    );

    assign o_mix.valid = r_vld[NSTAGE];
    assign o_mix.out_0 = w_mout[0];
    assign o_mix.out_1 = w_mout[1];
    assign o_mix.out_2 = w_mout[2];
    assign o_mix.out_3 = w_mout[3];

endmodule

`default_nettype wire
